### rtl/kqa_pkg.sv
package kqa_pkg;

    // Field widths of one item and one result
    localparam int KEY_W    = 32;
    localparam int AMOUNT_W = 16;
    localparam int SLOT_W   = 6;
    localparam int TOTAL_W  = 24;
    localparam int STATUS_W = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED = 2'd0,
        ST_NEW   = 2'd1,
        ST_FULL  = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

endpackage

### rtl/kqa_ram.sv
module kqa_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/keyed_quantity_accumulator_unit.sv
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+------------------------------------
// request   | part_key, amount               | taken when start && !busy
// result    | slot, total, status            | done high for one cycle, no stall
//
// With an empty table an item is appended directly from IDLE; otherwise the
// key search reads the key memory one slot a cycle from slot 0, and a hit
// passes through the ADD state to read and write back the total memory.
// The result is registered and appears in the cycle after the last work cycle; busy is low again
// in that cycle, so the next item may be taken while the result is shown.
// Reset clears the state, the fill count and done; memory contents are never cleared.
module keyed_quantity_accumulator_unit
    import kqa_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [KEY_W-1:0]    part_key,
    input  logic [AMOUNT_W-1:0] amount,
    output logic                busy,
    output logic                done,
    output logic [SLOT_W-1:0]   slot,
    output logic [TOTAL_W-1:0]  total,
    output logic [STATUS_W-1:0] status
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int SW = (AW > SLOT_W) ? AW : SLOT_W;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        ADD
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [AMOUNT_W-1:0] amt_reg, amt_next;
    logic                done_reg, done_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    status_t             status_reg, status_next;

    // Memory ports
    logic               key_we, tot_we;
    logic [AW-1:0]      key_waddr, tot_waddr, key_raddr, tot_raddr;
    logic [KEY_W-1:0]   key_wdata, key_rdata;
    logic [TOTAL_W-1:0] tot_wdata, tot_rdata;

    logic [TOTAL_W:0]   sum;
    logic               last_slot;
    logic               table_full;

    kqa_ram #(.DEPTH(ENTRIES), .WIDTH(KEY_W)) u_keys (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    kqa_ram #(.DEPTH(ENTRIES), .WIDTH(TOTAL_W)) u_totals (
        .clk   (clk),
        .we    (tot_we),
        .waddr (tot_waddr),
        .wdata (tot_wdata),
        .raddr (tot_raddr),
        .rdata (tot_rdata)
    );

    assign sum        = {1'b0, tot_rdata} + (TOTAL_W + 1)'(amt_reg);
    assign last_slot  = (CW'(idx_reg) + CW'(1)) == fill_reg;
    assign table_full = fill_reg == CW'(ENTRIES);

    // Search sequencer and result formation
    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        amt_next    = amt_reg;
        done_next   = 1'b0;
        slot_next   = slot_reg;
        total_next  = total_reg;
        status_next = status_reg;

        key_we    = 1'b0;
        tot_we    = 1'b0;
        key_waddr = fill_reg[AW-1:0];
        key_wdata = key_reg;
        tot_waddr = fill_reg[AW-1:0];
        tot_wdata = TOTAL_W'(amt_reg);
        key_raddr = '0;
        tot_raddr = idx_reg;

        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    key_next = part_key;
                    amt_next = amount;
                    idx_next = '0;
                    if (fill_reg == '0)
                    begin
                        // empty table: append at slot 0 right away
                        key_we      = 1'b1;
                        key_waddr   = '0;
                        key_wdata   = part_key;
                        tot_we      = 1'b1;
                        tot_waddr   = '0;
                        tot_wdata   = TOTAL_W'(amount);
                        fill_next   = CW'(1);
                        done_next   = 1'b1;
                        slot_next   = '0;
                        total_next  = TOTAL_W'(amount);
                        status_next = ST_NEW;
                    end
                    else
                    begin
                        state_next = SCAN;
                    end
                end
            end

            SCAN:
            begin
                if (key_rdata == key_reg)
                begin
                    // hit: fetch the total of this slot
                    tot_raddr  = idx_reg;
                    state_next = ADD;
                end
                else if (last_slot)
                begin
                    state_next = IDLE;
                    done_next  = 1'b1;
                    if (table_full)
                    begin
                        slot_next   = '0;
                        total_next  = '0;
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        key_we      = 1'b1;
                        tot_we      = 1'b1;
                        fill_next   = fill_reg + CW'(1);
                        slot_next   = SLOT_W'(SW'(fill_reg[AW-1:0]));
                        total_next  = TOTAL_W'(amt_reg);
                        status_next = ST_NEW;
                    end
                end
                else
                begin
                    idx_next  = idx_reg + AW'(1);
                    key_raddr = idx_reg + AW'(1);
                end
            end

            ADD:
            begin
                tot_we     = 1'b1;
                tot_waddr  = idx_reg;
                state_next = IDLE;
                done_next  = 1'b1;
                slot_next  = SLOT_W'(SW'(idx_reg));
                if (sum[TOTAL_W])
                begin
                    tot_wdata   = TOTAL_MAX;
                    total_next  = TOTAL_MAX;
                    status_next = ST_SAT;
                end
                else
                begin
                    tot_wdata   = sum[TOTAL_W-1:0];
                    total_next  = sum[TOTAL_W-1:0];
                    status_next = ST_ADDED;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        amt_reg    <= amt_next;
        slot_reg   <= slot_next;
        total_reg  <= total_next;
        status_reg <= status_next;
    end

    assign busy   = state_reg != IDLE;
    assign done   = done_reg;
    assign slot   = slot_reg;
    assign total  = total_reg;
    assign status = status_reg;

endmodule

### rtl/kqa_checker.sv
module kqa_checker
    import kqa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [SLOT_W-1:0]   slot,
    input logic [TOTAL_W-1:0]  total,
    input logic [STATUS_W-1:0] status
);

    // A result is shown only once the unit is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // An accepted item either starts a search or finishes at once
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item left no trace");

    // Dropped items carry empty fields
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (slot == '0 && total == '0))
        else $error("dropped item with nonzero fields");

    // Saturation pins the total at its ceiling
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_SAT) |-> (total == TOTAL_MAX))
        else $error("saturated total below ceiling");

    // A fresh entry holds a single amount
    a_new: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_NEW) |-> (total[TOTAL_W-1:AMOUNT_W] == '0))
        else $error("new entry total exceeds one amount");

endmodule

bind keyed_quantity_accumulator_unit kqa_checker u_kqa_checker (.*);
